// ----- src/tdc_pkg.sv -----
// ---------------------------------------------------------------------------
// tdc_pkg: shared definitions for the tacho dwell capture unit
// Opcodes, register indexes, capture kinds, reset values and the request
// structs that pass between the control logic and the capture store.
// ---------------------------------------------------------------------------
package tdc_pkg;

  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int OP_W    = 3;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 16;
  localparam int REG_W   = 2;

  localparam int CAPTURE_DEPTH_DEF = 13;
  localparam int TIMER_WIDTH_DEF   = 32;

  // Item opcodes
  localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
  localparam logic [OP_W-1:0] OP_TACHO   = 3'd1;
  localparam logic [OP_W-1:0] OP_IGN     = 3'd2;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 3'd3;
  localparam logic [OP_W-1:0] OP_READ    = 3'd4;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_TACHO_OFFSET   = 2'd0;
  localparam logic [REG_W-1:0] REG_GATE_THRESHOLD = 2'd1;
  localparam logic [REG_W-1:0] REG_END_OFFSET     = 2'd2;
  localparam logic [REG_W-1:0] REG_START_OFFSET   = 2'd3;

  localparam logic [15:0] TACHO_OFFSET_RST   = 16'd671;
  localparam logic [15:0] GATE_THRESHOLD_RST = 16'd100;
  localparam logic [7:0]  END_OFFSET_RST     = 8'd56;
  localparam logic [7:0]  START_OFFSET_RST   = 8'd19;

  // Capture kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_START = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  // Store selector: 0 dwell start, 1 dwell end
  localparam logic SEL_START = 1'b0;
  localparam logic SEL_END   = 1'b1;

  typedef struct packed {
    logic               en;
    logic               sel;
    logic [INDEX_W-1:0] addr;
    logic [DATA_W-1:0]  data;
  } cap_wr_t;

  typedef struct packed {
    logic               en;
    logic               hit;
    logic               sel;
    logic [INDEX_W-1:0] addr;
  } cap_rd_t;

endpackage

// ----- src/tacho_dwell_capture_unit.sv -----
// ---------------------------------------------------------------------------
// tacho_dwell_capture_unit: ignition timing capture
// Microsecond timer, tacho period capture and dwell start/end timestamps.
// ---------------------------------------------------------------------------
// The unit takes one item per clock cycle and returns exactly one result per
// item, in the cycle after the item is accepted; read_data comes from the
// registered read port of the capture store. The result register is a single
// stage: a new item is taken when the output is empty or when the waiting
// result is taken in the same cycle, so a stalled result holds the input back.
// The timer, pulse count, gates and indices live in flip-flops and are updated
// in the cycle an item is accepted, so consecutive items see each other's
// effects without any stall. The capture stores have no reset; an entry that
// was never written reads back as whatever it holds.
module tacho_dwell_capture_unit #(
  parameter int CAPTURE_DEPTH = tdc_pkg::CAPTURE_DEPTH_DEF,
  parameter int TIMER_WIDTH   = tdc_pkg::TIMER_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // [0] pin_level, [1] read_select, [5:2] read_index, [7:6] zero
  input  logic [7:0]                s_tdata,
  // [2:0] opcode
  input  logic [2:0]                s_tuser,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // [31:0] period, [35:32] capture_index, [67:36] capture_value,
  // [99:68] read_data, [103:100] zero
  output logic [103:0]              m_tdata,
  // [0] period_valid, [1] math_ready, [2] clear_screen, [4:3] capture_kind,
  // [7:5] zero
  output logic [7:0]                m_tuser,
  input  logic                      cfg_we,
  input  logic [tdc_pkg::REG_W-1:0] cfg_index,
  input  logic [tdc_pkg::CFG_W-1:0] cfg_data
);

  localparam int DW = tdc_pkg::DATA_W;
  localparam int IW = tdc_pkg::INDEX_W;
  localparam logic [IW-1:0] LAST_IDX = IW'(CAPTURE_DEPTH - 1);
  localparam logic [IW:0]   DEPTH_X  = (IW + 1)'(CAPTURE_DEPTH);

  // Configuration
  logic [15:0] tacho_offset;
  logic [15:0] gate_threshold;
  logic [7:0]  end_offset;
  logic [7:0]  start_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      tacho_offset   <= tdc_pkg::TACHO_OFFSET_RST;
      gate_threshold <= tdc_pkg::GATE_THRESHOLD_RST;
      end_offset     <= tdc_pkg::END_OFFSET_RST;
      start_offset   <= tdc_pkg::START_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tdc_pkg::REG_TACHO_OFFSET:   tacho_offset   <= cfg_data;
        tdc_pkg::REG_GATE_THRESHOLD: gate_threshold <= cfg_data;
        tdc_pkg::REG_END_OFFSET:     end_offset     <= cfg_data[7:0];
        tdc_pkg::REG_START_OFFSET:   start_offset   <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // Control state
  logic [TIMER_WIDTH-1:0] timer, timer_next;
  logic [1:0]             pulse_count, pulse_count_next;
  logic                   tacho_gate, tacho_gate_next;
  logic                   ignition_gate, ignition_gate_next;
  logic [IW-1:0]          start_index, start_index_next;
  logic [IW-1:0]          end_index, end_index_next;
  logic [DW-1:0]          period_reg, period_reg_next;

  // Item fields
  logic [2:0]    opcode;
  logic          pin_level;
  logic          read_select;
  logic [IW-1:0] read_index;
  logic          accept;
  logic [DW-1:0] timer_ext;

  // Result fields other than read_data
  logic          period_valid;
  logic          math_ready;
  logic          clear_screen;
  logic [1:0]    capture_kind;
  logic [IW-1:0] capture_index;
  logic [DW-1:0] capture_value;

  tdc_pkg::cap_wr_t wr;
  tdc_pkg::cap_rd_t rd;
  logic [DW-1:0]    read_data;

  assign opcode      = s_tuser;
  assign pin_level   = s_tdata[0];
  assign read_select = s_tdata[1];
  assign read_index  = s_tdata[5:2];
  assign s_tready    = !m_tvalid || m_tready;
  assign accept      = s_tvalid && s_tready;
  assign timer_ext   = DW'(timer);

  always_comb begin
    timer_next         = timer;
    pulse_count_next   = pulse_count;
    tacho_gate_next    = tacho_gate;
    ignition_gate_next = ignition_gate;
    start_index_next   = start_index;
    end_index_next     = end_index;
    period_reg_next    = period_reg;
    period_valid       = 1'b0;
    math_ready         = 1'b0;
    clear_screen       = 1'b0;
    capture_kind       = tdc_pkg::KIND_NONE;
    capture_index      = '0;
    capture_value      = '0;
    wr                 = '0;
    rd.en              = accept;
    rd.hit             = 1'b0;
    rd.sel             = read_select;
    rd.addr            = read_index;

    case (opcode)
      tdc_pkg::OP_TICK: begin
        timer_next = timer + 1'b1;
      end
      tdc_pkg::OP_TACHO: begin
        if (tacho_gate) begin
          period_reg_next  = timer_ext - DW'(tacho_offset);
          period_valid     = 1'b1;
          timer_next       = '0;
          pulse_count_next = pulse_count + 1'b1;
          // Third pulse ends the measurement; second pulse opens the window.
          if (pulse_count_next == 2'd3) begin
            tacho_gate_next    = 1'b0;
            ignition_gate_next = 1'b0;
            math_ready         = 1'b1;
          end
          if (pulse_count_next == 2'd2) begin
            start_index_next   = '0;
            end_index_next     = '0;
            ignition_gate_next = 1'b1;
          end
        end
      end
      tdc_pkg::OP_IGN: begin
        if (ignition_gate && (timer_ext > DW'(gate_threshold))) begin
          if (pin_level == 1'b0) begin
            capture_kind   = tdc_pkg::KIND_END;
            capture_index  = end_index;
            capture_value  = timer_ext - DW'(end_offset);
            end_index_next = (end_index < LAST_IDX) ? end_index + 1'b1 : end_index;
            wr.sel         = tdc_pkg::SEL_END;
          end else begin
            capture_kind     = tdc_pkg::KIND_START;
            capture_index    = start_index;
            capture_value    = timer_ext - DW'(start_offset);
            start_index_next = (start_index < LAST_IDX) ? start_index + 1'b1 : start_index;
            wr.sel           = tdc_pkg::SEL_START;
          end
          wr.en   = accept;
          wr.addr = capture_index;
          wr.data = capture_value;
        end
      end
      tdc_pkg::OP_TIMEOUT: begin
        clear_screen     = (pulse_count == 2'd0);
        tacho_gate_next  = 1'b1;
        pulse_count_next = '0;
      end
      tdc_pkg::OP_READ: begin
        rd.hit = ({1'b0, read_index} < DEPTH_X);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timer         <= '0;
      pulse_count   <= '0;
      tacho_gate    <= 1'b1;
      ignition_gate <= 1'b0;
      start_index   <= '0;
      end_index     <= '0;
      period_reg    <= '0;
    end else if (accept) begin
      timer         <= timer_next;
      pulse_count   <= pulse_count_next;
      tacho_gate    <= tacho_gate_next;
      ignition_gate <= ignition_gate_next;
      start_index   <= start_index_next;
      end_index     <= end_index_next;
      period_reg    <= period_reg_next;
    end
  end

  tdc_capture_store #(
    .CAPTURE_DEPTH(CAPTURE_DEPTH)
  ) u_store (
    .clk  (clk),
    .wr   (wr),
    .rd   (rd),
    .rdata(read_data)
  );

  // Result register
  logic [DW-1:0] out_period;
  logic [IW-1:0] out_capture_index;
  logic [DW-1:0] out_capture_value;
  logic [4:0]    out_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_period        <= period_reg_next;
      out_capture_index <= capture_index;
      out_capture_value <= capture_value;
      out_flags         <= {capture_kind, clear_screen, math_ready, period_valid};
    end
  end

  assign m_tdata = {4'b0, read_data, out_capture_value, out_capture_index, out_period};
  assign m_tuser = {3'b0, out_flags};

endmodule

// ----- src/tdc_capture_store.sv -----
// ---------------------------------------------------------------------------
// tdc_capture_store: dwell start and dwell end timestamp memories
// Two synchronous memories with one write port and a registered read port.
// The read result holds until the next request with rd.en set is taken.
// ---------------------------------------------------------------------------
module tdc_capture_store #(
  parameter int CAPTURE_DEPTH = tdc_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                      clk,
  input  tdc_pkg::cap_wr_t          wr,
  input  tdc_pkg::cap_rd_t          rd,
  output logic [tdc_pkg::DATA_W-1:0] rdata
);

  localparam int IDXW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;

  logic [tdc_pkg::DATA_W-1:0] start_mem [CAPTURE_DEPTH];
  logic [tdc_pkg::DATA_W-1:0] end_mem   [CAPTURE_DEPTH];

  logic [tdc_pkg::DATA_W-1:0] start_q;
  logic [tdc_pkg::DATA_W-1:0] end_q;
  logic                       sel_q;
  logic                       hit_q;

  always_ff @(posedge clk) begin
    if (wr.en && (wr.sel == tdc_pkg::SEL_START)) begin
      start_mem[wr.addr[IDXW-1:0]] <= wr.data;
    end
    if (wr.en && (wr.sel == tdc_pkg::SEL_END)) begin
      end_mem[wr.addr[IDXW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      start_q <= start_mem[rd.addr[IDXW-1:0]];
      end_q   <= end_mem[rd.addr[IDXW-1:0]];
      sel_q   <= rd.sel;
      hit_q   <= rd.hit;
    end
  end

  // Items other than an in-range read return zero.
  assign rdata = !hit_q ? '0 : ((sel_q == tdc_pkg::SEL_END) ? end_q : start_q);

endmodule
